// ===== src/pfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfp_pkg
// Shared types and constants for the packet frame parser.
// ----------------------------------------------------------------------------
package pfp_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 6;
    localparam int SEQ_W  = 5;
    localparam int TYPE_W = 5;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = '1;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [2:0] {
        PH_MARKER  = 3'd0,
        PH_HDR1    = 3'd1,
        PH_HDR2    = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHECK   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TOO_LONG = 2'd1,
        ST_BAD_SUM  = 2'd2
    } t_status;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [LEN_W-1:0]  payload_index;
        logic [BYTE_W-1:0] marker;
        logic [LEN_W-1:0]  length;
        logic [SEQ_W-1:0]  sequence_res;
        logic [TYPE_W-1:0] frame_type;
        t_status           status;
        logic              frame_end;
    } t_result;

endpackage
`default_nettype wire

// ===== src/pfp_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfp_in_reg
// Input register: captures one received byte and holds it until the parser
// takes it.
// ----------------------------------------------------------------------------
module pfp_in_reg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic [pfp_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                            o_in_stall,
    input  wire logic                       i_take,
    output logic                            o_valid,
    output logic [pfp_pkg::BYTE_W-1:0]      o_byte
);
    import pfp_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              accept;

    assign o_in_stall = r_valid && !i_take;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule
`default_nettype wire

// ===== src/pfp_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfp_parse
// Frame state machine: header capture, payload counting, running XOR and
// the results for payload bytes and frame ends.
// ----------------------------------------------------------------------------
module pfp_parse (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [pfp_pkg::LEN_W-1:0]  i_max_payload,
    input  wire logic                       i_take,
    input  wire logic [pfp_pkg::BYTE_W-1:0] i_byte,
    output logic                            o_res_valid,
    output pfp_pkg::t_result                o_res
);
    import pfp_pkg::*;

    t_phase            r_phase, n_phase;
    logic [LEN_W-1:0]  r_bytes_left, n_bytes_left;
    logic [BYTE_W-1:0] r_xor, n_xor;
    logic [BYTE_W-1:0] r_marker, n_marker;
    logic [LEN_W-1:0]  r_length, n_length;
    logic [SEQ_W-1:0]  r_seq, n_seq;
    logic [TYPE_W-1:0] r_type, n_type;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_MARKER;
            r_bytes_left <= '0;
            r_xor        <= '0;
            r_marker     <= '0;
            r_length     <= '0;
            r_seq        <= '0;
            r_type       <= '0;
        end else if (i_take) begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_xor        <= n_xor;
            r_marker     <= n_marker;
            r_length     <= n_length;
            r_seq        <= n_seq;
            r_type       <= n_type;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_xor        = r_xor ^ i_byte;
        n_marker     = r_marker;
        n_length     = r_length;
        n_seq        = r_seq;
        n_type       = r_type;
        o_res_valid  = 1'b0;
        o_res.kind          = KIND_BYTE;
        o_res.payload_byte  = '0;
        o_res.payload_index = '0;
        o_res.status        = ST_OK;
        o_res.frame_end     = 1'b0;

        unique case (r_phase)
            PH_HDR1: begin
                n_length = i_byte[7:2];
                n_seq    = {i_byte[1:0], 3'b000};
                n_phase  = PH_HDR2;
            end
            PH_HDR2: begin
                n_seq  = {r_seq[4:3], i_byte[7:5]};
                n_type = i_byte[4:0];
                if (r_length > i_max_payload) begin
                    o_res_valid     = 1'b1;
                    o_res.kind      = KIND_END;
                    o_res.status    = ST_TOO_LONG;
                    o_res.frame_end = 1'b1;
                    n_phase         = PH_MARKER;
                end else begin
                    n_bytes_left = r_length;
                    n_phase      = (r_length == '0) ? PH_CHECK : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                o_res_valid         = 1'b1;
                o_res.payload_byte  = i_byte;
                o_res.payload_index = r_length - r_bytes_left;
                n_bytes_left        = r_bytes_left - 1'b1;
                if (n_bytes_left == '0) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                o_res_valid     = 1'b1;
                o_res.kind      = KIND_END;
                o_res.status    = (i_byte == r_xor) ? ST_OK : ST_BAD_SUM;
                o_res.frame_end = 1'b1;
                n_phase         = PH_MARKER;
            end
            default: begin
                // any other code behaves as the marker byte
                n_marker     = i_byte;
                n_xor        = i_byte;
                n_length     = '0;
                n_seq        = '0;
                n_type       = '0;
                n_bytes_left = '0;
                n_phase      = PH_HDR1;
            end
        endcase

        // header fields as they stand after this byte
        o_res.marker       = n_marker;
        o_res.length       = n_length;
        o_res.sequence_res = n_seq;
        o_res.frame_type   = n_type;
    end

`ifndef ASSERT_OFF
    a_end_to_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && o_res_valid && o_res.frame_end |=> r_phase == PH_MARKER)
        else $error("frame end did not return to marker phase");

    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_bytes_left != '0)
        else $error("payload phase with no bytes left");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_left <= r_length)
        else $error("bytes left exceeds header length");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_take |=> $stable(r_phase) && $stable(r_xor))
        else $error("state changed without a byte");
`endif

endmodule
`default_nettype wire

// ===== src/pfp_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfp_out_reg
// Result register: holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module pfp_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire pfp_pkg::t_result i_res,
    output logic                  o_ready,
    input  wire logic             i_out_stall,
    output logic                  o_out_valid,
    output pfp_pkg::t_result      o_res
);
    import pfp_pkg::*;

    logic    r_valid;
    t_result r_res;

    // free when empty or when the held item leaves this cycle
    assign o_ready = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_res       = r_res;

endmodule
`default_nettype wire

// ===== src/packet_frame_parser_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// packet_frame_parser_core
// Splits a byte stream into length-prefixed frames with an XOR checksum.
// ----------------------------------------------------------------------------
// A result is registered in the result register after its byte leaves the input register.
// Throughput: 1 byte per cycle when no result stalls; the frame state updates once per byte.
// A stalled result holds the parser; intake stops once the input register is full.
// Reset (synchronous, active low): empty registers, marker phase, max_payload 63.
module packet_frame_parser_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [pfp_pkg::LEN_W-1:0]  i_cfg_max_payload,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [pfp_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic                            o_kind,
    output logic [pfp_pkg::BYTE_W-1:0]      o_payload_byte,
    output logic [pfp_pkg::LEN_W-1:0]       o_payload_index,
    output logic [pfp_pkg::BYTE_W-1:0]      o_marker,
    output logic [pfp_pkg::LEN_W-1:0]       o_length,
    output logic [pfp_pkg::SEQ_W-1:0]       o_sequence_res,
    output logic [pfp_pkg::TYPE_W-1:0]      o_frame_type,
    output logic [1:0]                      o_status,
    output logic                            o_frame_end
);
    import pfp_pkg::*;

    logic [LEN_W-1:0]  r_max_payload;
    logic              byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic              out_ready;
    logic              take;
    logic              res_valid;
    t_result           res;
    t_result           out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (i_cfg_we) begin
            r_max_payload <= i_cfg_max_payload;
        end
    end

    // advance a byte only when the result register has room, whether or not the byte yields a result
    assign take = byte_valid && out_ready;

    pfp_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_rx_byte  (i_rx_byte),
        .o_in_stall (o_in_stall),
        .i_take     (take),
        .o_valid    (byte_valid),
        .o_byte     (byte_data)
    );

    pfp_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_max_payload (r_max_payload),
        .i_take        (take),
        .i_byte        (byte_data),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    pfp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (take && res_valid),
        .i_res       (res),
        .o_ready     (out_ready),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_res       (out_res)
    );

    assign o_kind          = out_res.kind;
    assign o_payload_byte  = out_res.payload_byte;
    assign o_payload_index = out_res.payload_index;
    assign o_marker        = out_res.marker;
    assign o_length        = out_res.length;
    assign o_sequence_res  = out_res.sequence_res;
    assign o_frame_type    = out_res.frame_type;
    assign o_status        = out_res.status;
    assign o_frame_end     = out_res.frame_end;

endmodule
`default_nettype wire
